// ===== src/thpm_pkg.sv =====
// Package: shared widths, defaults, hit record and control types for the TDC hit pair matcher.
package thpm_pkg;

   localparam int MAX_HITS_DEF = 16;
   localparam int TDC_BITS_DEF = 20;
   localparam int MAX_RESULTS  = 64;
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam int SECTOR_W = 4;
   localparam int LAYER_W  = 2;
   localparam int COMP_W   = 4;
   localparam int TDC_W    = 20;
   localparam int RES_W    = 21;

   localparam logic [COMP_W-1:0] BAR_COMPONENT_RESET = 4'd10;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [LAYER_W-1:0]  layer;
      logic [COMP_W-1:0]   component;
      logic                order;
      logic [TDC_W-1:0]    tdc;
   } hit_type;

   localparam int HIT_W = $bits(hit_type);

   // sequencer to pair unit
   typedef struct packed {
      logic lat_a;   // read data holds the order-0 candidate
      logic chk;     // read data holds an order-1 candidate
      logic finish;  // scan done, close the event
      logic ovf;     // event dropped hits
   } seq_ctl_type;

endpackage

// ===== src/tdc_hit_pair_matcher_top.sv =====
// Top level of the TDC hit pair matcher: configuration register, hit store and scan.
//
// The matcher collects the hits of one event in a MAX_HITS deep store, one hit per cycle
// while req_stall is low, and on the end-of-event hit pairs every order-0 bar hit with
// every order-1 bar hit of the same sector and layer, in arrival order. The scan then runs
// over the single read port of the store: each stored hit is read and then checked, and
// each order-0 bar hit then streams all stored hits past it; rsp_stall on the output can
// hold the scan. req_stall is high from the end-of-event hit until the event's last item
// has moved into the output register. At most 64 pair items go out per event; an event
// without a pair gives one item with rsp_pair_valid low. Hits beyond the store are dropped
// and flagged on every item of the event. The store needs no clear after reset. Write
// csr_write_data (bar component, reset 10) only while the block is idle.
module tdc_hit_pair_matcher_top import thpm_pkg::*; #(
   parameter int MAX_HITS = MAX_HITS_DEF,
   parameter int TDC_BITS = TDC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [COMP_W-1:0]       csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SECTOR_W-1:0]     req_sector,
   input  logic [LAYER_W-1:0]      req_layer,
   input  logic [COMP_W-1:0]       req_component,
   input  logic                    req_readout_order,
   input  logic [TDC_W-1:0]        req_tdc_value,
   input  logic                    req_end_of_event,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_pair_valid,
   output logic [SECTOR_W-1:0]     rsp_module_res,
   output logic [LAYER_W-1:0]      rsp_pair_layer,
   output logic signed [RES_W-1:0] rsp_time_diff,
   output logic [RES_W-1:0]        rsp_time_sum,
   output logic                    rsp_hit_overflow,
   output logic                    rsp_last_result
);

   localparam int IDX_W = $clog2(MAX_HITS);

   logic [COMP_W-1:0] bar_ff;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   hit_type           wr_data, rd_data;
   logic [HIT_W-1:0]  rd_raw;
   seq_ctl_type       ctl;
   logic              pair_hold;

   // bar component register
   always_ff @(posedge clock) begin
      if (reset) begin
         bar_ff <= BAR_COMPONENT_RESET;
      end else if (csr_write_enable) begin
         bar_ff <= csr_write_data;
      end
   end

   // hit store: written only while loading, read only while scanning, so the two
   // ports never touch the same entry in one cycle
   thpm_ram #(
      .WIDTH (HIT_W),
      .DEPTH (MAX_HITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data = rd_raw;

   thpm_seq #(
      .MAX_HITS (MAX_HITS),
      .TDC_BITS (TDC_BITS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sector        (req_sector),
      .req_layer         (req_layer),
      .req_component     (req_component),
      .req_readout_order (req_readout_order),
      .req_tdc_value     (req_tdc_value),
      .req_end_of_event  (req_end_of_event),
      .bar_component     (bar_ff),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .ctl               (ctl),
      .pair_hold         (pair_hold)
   );

   // compare, stage the newest pair, drive the output register
   thpm_pair u_pair (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .rd_data          (rd_data),
      .bar_component    (bar_ff),
      .pair_hold        (pair_hold),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pair_valid   (rsp_pair_valid),
      .rsp_module_res   (rsp_module_res),
      .rsp_pair_layer   (rsp_pair_layer),
      .rsp_time_diff    (rsp_time_diff),
      .rsp_time_sum     (rsp_time_sum),
      .rsp_hit_overflow (rsp_hit_overflow),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== src/thpm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module thpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/thpm_seq.sv =====
// Sequencer: loads hits into the store and walks the pair scan over it.
module thpm_seq import thpm_pkg::*; #(
   parameter int MAX_HITS = MAX_HITS_DEF,
   parameter int TDC_BITS = TDC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [SECTOR_W-1:0]         req_sector,
   input  logic [LAYER_W-1:0]          req_layer,
   input  logic [COMP_W-1:0]           req_component,
   input  logic                        req_readout_order,
   input  logic [TDC_W-1:0]            req_tdc_value,
   input  logic                        req_end_of_event,
   input  logic [COMP_W-1:0]           bar_component,
   output logic                        wr_en,
   output logic [$clog2(MAX_HITS)-1:0] wr_addr,
   output hit_type                     wr_data,
   output logic                        rd_en,
   output logic [$clog2(MAX_HITS)-1:0] rd_addr,
   input  hit_type                     rd_data,
   output seq_ctl_type                 ctl,
   input  logic                        pair_hold
);

   localparam int IDX_W = $clog2(MAX_HITS);
   localparam int CNT_W = $clog2(MAX_HITS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HITS);
   localparam logic [TDC_W-1:0] TDC_MASK = (TDC_BITS >= TDC_W) ? {TDC_W{1'b1}} :
                                           TDC_W'((64'd1 << TDC_BITS) - 64'd1);

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_RDA  = 3'd1;
   localparam logic [2:0] S_CHKA = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] i_next;

   assign req_stall = (state_ff != S_LOAD);

   assign wr_addr           = cnt_ff[IDX_W-1:0];
   assign wr_data.sector    = req_sector;
   assign wr_data.layer     = req_layer;
   assign wr_data.component = req_component;
   assign wr_data.order     = req_readout_order;
   assign wr_data.tdc       = req_tdc_value & TDC_MASK;

   assign i_next = i_ff + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = i_ff[IDX_W-1:0];
      ctl        = '0;
      ctl.ovf    = ovf_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CNT_MAX) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_event) begin
                  i_in     = '0;
                  state_in = S_RDA;
               end
            end
         end
         S_RDA: begin
            rd_en    = 1'b1;
            state_in = S_CHKA;
         end
         S_CHKA: begin
            ctl.lat_a = 1'b1;
            if (!rd_data.order && rd_data.component == bar_component) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               j_in     = CNT_W'(1);
               state_in = S_SCAN;
            end else begin
               i_in     = i_next;
               state_in = (i_next < cnt_ff) ? S_RDA : S_DONE;
            end
         end
         S_SCAN: begin
            ctl.chk = 1'b1;
            // hold the scan index and read data while the pair unit holds
            if (!pair_hold) begin
               if (j_ff < cnt_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = j_ff[IDX_W-1:0];
                  j_in    = j_ff + CNT_W'(1);
               end else begin
                  i_in     = i_next;
                  state_in = (i_next < cnt_ff) ? S_RDA : S_DONE;
               end
            end
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            if (!pair_hold) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

endmodule

// ===== src/thpm_pair.sv =====
// Pair unit: compares candidates, forms difference and sum, stages results to the output.
module thpm_pair import thpm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  seq_ctl_type                ctl,
   input  hit_type                    rd_data,
   input  logic [COMP_W-1:0]          bar_component,
   output logic                       pair_hold,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_pair_valid,
   output logic [SECTOR_W-1:0]        rsp_module_res,
   output logic [LAYER_W-1:0]         rsp_pair_layer,
   output logic signed [RES_W-1:0]    rsp_time_diff,
   output logic [RES_W-1:0]           rsp_time_sum,
   output logic                       rsp_hit_overflow,
   output logic                       rsp_last_result
);

   localparam logic [RES_CNT_W-1:0] RES_CAP = RES_CNT_W'(MAX_RESULTS);

   hit_type a_ff;

   // newest pair waits here until it is known whether it closes the event
   logic                 pend_valid_ff, pend_valid_in;
   logic [SECTOR_W-1:0]  pend_mod_ff;
   logic [LAYER_W-1:0]   pend_lay_ff;
   logic [RES_W-1:0]     pend_diff_ff;
   logic [RES_W-1:0]     pend_sum_ff;
   logic [RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_pv_ff;
   logic [SECTOR_W-1:0]  out_mod_ff;
   logic [LAYER_W-1:0]   out_lay_ff;
   logic [RES_W-1:0]     out_diff_ff;
   logic [RES_W-1:0]     out_sum_ff;
   logic                 out_ovf_ff;
   logic                 out_last_ff;

   logic             match, take, out_free, load_mid, load_end;
   logic [RES_W-1:0] diff, sum;

   assign match = ctl.chk && rd_data.order && rd_data.component == bar_component &&
                  rd_data.sector == a_ff.sector && rd_data.layer == a_ff.layer;
   assign take  = match && (res_cnt_ff != RES_CAP);
   assign diff  = {1'b0, a_ff.tdc} - {1'b0, rd_data.tdc};
   assign sum   = {1'b0, a_ff.tdc} + {1'b0, rd_data.tdc};

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pair_hold = ((take && pend_valid_ff) || ctl.finish) && !out_free;
   assign load_mid  = take && pend_valid_ff && out_free;
   assign load_end  = ctl.finish && out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      res_cnt_in    = res_cnt_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      if (take && !pair_hold) begin
         pend_valid_in = 1'b1;
         res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
      end
      if (load_mid || load_end) begin
         out_valid_in = 1'b1;
      end
      if (load_end) begin
         pend_valid_in = 1'b0;
         res_cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         res_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         res_cnt_ff    <= res_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.lat_a) begin
         a_ff <= rd_data;
      end
      if (take && !pair_hold) begin
         pend_mod_ff  <= a_ff.sector;
         pend_lay_ff  <= a_ff.layer;
         pend_diff_ff <= diff;
         pend_sum_ff  <= sum;
      end
      if (load_mid || (load_end && pend_valid_ff)) begin
         out_pv_ff   <= 1'b1;
         out_mod_ff  <= pend_mod_ff;
         out_lay_ff  <= pend_lay_ff;
         out_diff_ff <= pend_diff_ff;
         out_sum_ff  <= pend_sum_ff;
      end else if (load_end) begin
         out_pv_ff   <= 1'b0;
         out_mod_ff  <= '0;
         out_lay_ff  <= '0;
         out_diff_ff <= '0;
         out_sum_ff  <= '0;
      end
      if (load_mid || load_end) begin
         out_ovf_ff  <= ctl.ovf;
         out_last_ff <= load_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pair_valid   = out_pv_ff;
   assign rsp_module_res   = out_mod_ff;
   assign rsp_pair_layer   = out_lay_ff;
   assign rsp_time_diff    = $signed(out_diff_ff);
   assign rsp_time_sum     = out_sum_ff;
   assign rsp_hit_overflow = out_ovf_ff;
   assign rsp_last_result  = out_last_ff;

endmodule

// ===== src/thpm_checker.sv =====
// Port-level checks for the TDC hit pair matcher, bound to the top level.
module thpm_checker import thpm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_end_of_event,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_pair_valid,
   input logic [SECTOR_W-1:0]     rsp_module_res,
   input logic [LAYER_W-1:0]      rsp_pair_layer,
   input logic signed [RES_W-1:0] rsp_time_diff,
   input logic [RES_W-1:0]        rsp_time_sum,
   input logic                    rsp_hit_overflow,
   input logic                    rsp_last_result
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pair_valid) &&
      $stable(rsp_module_res) && $stable(rsp_pair_layer) && $stable(rsp_time_diff) &&
      $stable(rsp_time_sum) && $stable(rsp_hit_overflow) && $stable(rsp_last_result))
      else $error("rsp item changed while stalled");

   // accepting the end-of-event hit raises req_stall
   a_eoe_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_event |=> req_stall)
      else $error("hit accepted right after end of event");

   // the no-pair marker closes its event and carries zero fields
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pair_valid |-> rsp_last_result && rsp_module_res == '0 &&
      rsp_pair_layer == '0 && rsp_time_diff == '0 && rsp_time_sum == '0)
      else $error("malformed no-pair item");

   // sum and difference of the same two values share parity
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_valid |-> rsp_time_sum[0] == rsp_time_diff[0])
      else $error("time sum and difference disagree");

endmodule

bind tdc_hit_pair_matcher_top thpm_checker u_thpm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_end_of_event (req_end_of_event),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pair_valid   (rsp_pair_valid),
   .rsp_module_res   (rsp_module_res),
   .rsp_pair_layer   (rsp_pair_layer),
   .rsp_time_diff    (rsp_time_diff),
   .rsp_time_sum     (rsp_time_sum),
   .rsp_hit_overflow (rsp_hit_overflow),
   .rsp_last_result  (rsp_last_result)
);
